// ----- hdl/tipd_pkg.sv -----
// shared types, constants and color conversion for the tiled icon palette decoder
package tipd_pkg;

  localparam int FRAMES = 8;
  localparam int ROW_PIXELS = 32;
  localparam logic [8:0] ROW_LIMIT = 9'(FRAMES * ROW_PIXELS);
  localparam logic [4:0] LAST_COLUMN = 5'(ROW_PIXELS - 1);
  localparam int PAL_DEPTH = 16;

  typedef enum logic [1:0] {
    KIND_PAL  = 2'd0,
    KIND_ICON = 2'd1,
    KIND_ROW  = 2'd2
  } kind_t;

  typedef enum logic {
    SEQ_IDLE,
    SEQ_RUN
  } seq_state_t;

  typedef struct packed {
    logic        vld;
    logic [11:0] addr;
    logic [4:0]  x;
  } issue_t;

  typedef struct packed {
    logic       vld;
    logic [4:0] x;
  } tag_t;

  typedef struct packed {
    logic        we;
    logic [11:0] addr;
    logic [7:0]  data;
  } tile_wr_t;

  typedef struct packed {
    logic        we;
    logic [3:0]  addr;
    logic [14:0] data;
  } pal_wr_t;

  // bgr555 to rgb5a1, alpha set
  function automatic logic [15:0] to_rgb5a1(input logic [14:0] c);
    return {c[4:0], c[9:5], c[14:10], 1'b1};
  endfunction

endpackage

// ----- hdl/tipd_ifs.sv -----
// item channel interfaces for commands and pixels
interface tipd_cmd_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [11:0] index;
  logic [14:0] value;
  logic [7:0]  row;

  modport source (output valid, kind, index, value, row, input ready);
  modport sink (input valid, kind, index, value, row, output ready);
endinterface

interface tipd_pix_if;
  logic        valid;
  logic        ready;
  logic [15:0] pixel;
  logic [4:0]  column;
  logic        last;

  modport source (output valid, pixel, column, last, input ready);
  modport sink (input valid, pixel, column, last, output ready);
endinterface

// ----- hdl/tiled_icon_palette_decoder.sv -----
// Tiled 4-bit icon decoder: palette and tile loads are written when accepted. A row item
// reads the tile memory once per pixel through its single read port, and its first pixel
// passes the sequencer state, tile read, palette read and output register before it is
// valid. The next item is accepted once the last tile read of the row has passed into the
// palette stage; output backpressure stalls the whole row pipeline. Reads of palette or
// tile entries that were never loaded give undefined pixels.
module tiled_icon_palette_decoder
  import tipd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  tipd_cmd_if.sink   cmd,
  tipd_pix_if.source pix
);

  logic     accept;
  logic     start;
  logic     adv;
  logic     seq_idle;
  issue_t   iss;
  tag_t     tag_tile;
  tag_t     tag_pal;
  logic [7:0] tile_byte;
  tile_wr_t tile_wr;
  pal_wr_t  pal_wr;

  assign cmd.ready = seq_idle && !tag_tile.vld;
  assign accept    = cmd.valid && cmd.ready;
  assign start     = accept && cmd.kind == KIND_ROW && {1'b0, cmd.row} < ROW_LIMIT;

  always_comb begin
    tile_wr.we   = accept && cmd.kind == KIND_ICON;
    tile_wr.addr = cmd.index;
    tile_wr.data = cmd.value[7:0];
    pal_wr.we    = accept && cmd.kind == KIND_PAL && cmd.index[11:4] == 8'd0;
    pal_wr.addr  = cmd.index[3:0];
    pal_wr.data  = cmd.value;
  end

  tipd_row_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .start_row (cmd.row),
    .adv       (adv),
    .idle      (seq_idle),
    .iss       (iss)
  );

  tipd_tile_mem u_tile (
    .clk   (clk),
    .rst   (rst),
    .wr    (tile_wr),
    .adv   (adv),
    .iss   (iss),
    .tag   (tag_tile),
    .rdata (tile_byte)
  );

  tipd_palette u_pal (
    .clk       (clk),
    .rst       (rst),
    .wr        (pal_wr),
    .tag_in    (tag_tile),
    .tile_byte (tile_byte),
    .adv       (adv),
    .tag_pal   (tag_pal),
    .pix       (pix)
  );

  a_no_tile_write_in_row: assert property (@(posedge clk) disable iff (rst)
    tile_wr.we |-> !iss.vld && !tag_tile.vld)
    else $error("tile write while a row reads the tile memory");

  a_row_starts: assert property (@(posedge clk) disable iff (rst)
    start |=> iss.vld && iss.x == 5'd0)
    else $error("row item did not start the sequencer");

  a_column_steps: assert property (@(posedge clk) disable iff (rst)
    (pix.valid && pix.ready && !pix.last) |=>
      (!pix.valid || pix.column == $past(pix.column) + 5'd1))
    else $error("pixel columns out of order");

  a_last_column: assert property (@(posedge clk) disable iff (rst)
    pix.valid |-> (pix.last == (pix.column == LAST_COLUMN)))
    else $error("last flag does not match column");

  a_pal_stage_order: assert property (@(posedge clk) disable iff (rst)
    (tag_pal.vld && tag_tile.vld) |-> tag_tile.x == tag_pal.x + 5'd1)
    else $error("pipeline stages lost a column");

endmodule

// ----- hdl/tipd_row_seq.sv -----
// row sequencer: steps through the 32 columns and forms tile memory addresses
module tipd_row_seq
  import tipd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       start,
  input  logic [7:0] start_row,
  input  logic       adv,
  output logic       idle,
  output issue_t     iss
);

  seq_state_t state, state_next;
  logic [4:0] x;
  logic [7:0] row;

  always_comb begin
    state_next = state;
    unique case (state)
      SEQ_IDLE: if (start) state_next = SEQ_RUN;
      SEQ_RUN:  if (adv && x == LAST_COLUMN) state_next = SEQ_IDLE;
      default:  state_next = SEQ_IDLE;
    endcase
  end

  always_comb begin
    idle     = (state == SEQ_IDLE);
    iss.vld  = (state == SEQ_RUN);
    iss.x    = x;
    iss.addr = {row[7:3], x[4:3], row[2:0], x[2:1]};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= SEQ_IDLE;
      x     <= '0;
    end else begin
      state <= state_next;
      if (state == SEQ_IDLE && start) begin
        x <= '0;
      end else if (state == SEQ_RUN && adv) begin
        x <= x + 5'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == SEQ_IDLE && start) begin
      row <= start_row;
    end
  end

endmodule

// ----- hdl/tipd_tile_mem.sv -----
// tile byte memory with registered read and the matching pipeline tag
module tipd_tile_mem
  import tipd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  tile_wr_t   wr,
  input  logic       adv,
  input  issue_t     iss,
  output tag_t       tag,
  output logic [7:0] rdata
);

  logic [7:0] mem [4096];

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (adv) begin
      rdata <= mem[iss.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tag.vld <= 1'b0;
    end else if (adv) begin
      tag.vld <= iss.vld;
    end
    if (adv) begin
      tag.x <= iss.x;
    end
  end

endmodule

// ----- hdl/tipd_palette.sv -----
// palette memory, nibble select, color conversion and output register
module tipd_palette
  import tipd_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  pal_wr_t    wr,
  input  tag_t       tag_in,
  input  logic [7:0] tile_byte,
  output logic       adv,
  output tag_t       tag_pal,
  tipd_pix_if.source pix
);

  logic [14:0] mem [PAL_DEPTH];
  logic [3:0]  nib;
  logic [14:0] color;
  logic        zero;
  logic        out_vld;
  logic [15:0] out_pixel;
  logic [4:0]  out_column;
  logic        out_last;

  assign nib = tag_in.x[0] ? tile_byte[7:4] : tile_byte[3:0];
  assign adv = !out_vld || pix.ready;

  always_ff @(posedge clk) begin
    if (wr.we) begin
      mem[wr.addr] <= wr.data;
    end
    if (adv) begin
      color     <= mem[nib];
      zero      <= (nib == 4'd0);
      tag_pal.x <= tag_in.x;
      out_pixel  <= zero ? 16'd0 : to_rgb5a1(color);
      out_column <= tag_pal.x;
      out_last   <= (tag_pal.x == LAST_COLUMN);
    end
    if (rst) begin
      tag_pal.vld <= 1'b0;
      out_vld     <= 1'b0;
    end else if (adv) begin
      tag_pal.vld <= tag_in.vld;
      out_vld     <= tag_pal.vld;
    end
  end

  assign pix.valid  = out_vld;
  assign pix.pixel  = out_pixel;
  assign pix.column = out_column;
  assign pix.last   = out_last;

endmodule

// ----- tb/sv/tb_tiled_icon_palette_decoder.sv -----
`timescale 1ns / 100ps
// testbench for the tiled icon palette decoder: loads, row requests, pixel checks
module tb_tiled_icon_palette_decoder;
  import tipd_pkg::*;

  localparam logic [1:0] KIND_SPARE = 2'd3;
  localparam int STALL_LIMIT = 4000;
  localparam int RANDOM_ITEMS = 84;
  localparam int DRAIN_CYCLES = 40;

  typedef struct packed {
    logic [15:0] pixel;
    logic [4:0]  column;
    logic        last;
  } pix_item_t;

  class icon_row_checker;
    logic [14:0] palette [PAL_DEPTH];
    logic [7:0]  tiles [4096];
    pix_item_t   expected_pixels [$];
    int          mismatches;
    int          pixels_seen;

    function int tile_byte(int x, int y);
      int t;
      t = (y >> 3) * 4 + (x >> 3);
      return ((t * 8 + (y & 7)) * 4 + ((x & 7) >> 1)) & 4095;
    endfunction

    function logic [15:0] bgr_to_rgba(logic [14:0] c);
      int p;
      int r;
      p = c;
      r = (p << 11) | 1 | ((p << 1) & 'h07C0) | ((p >> 9) & 'h003E);
      return r[15:0];
    endfunction

    function void note_item(logic [1:0] kind, logic [11:0] index, logic [14:0] value,
                            logic [7:0] row);
      pix_item_t   e;
      logic [7:0]  b;
      logic [3:0]  nib;
      case (kind)
        KIND_PAL: begin
          if (index < PAL_DEPTH) palette[index[3:0]] = value;
        end
        KIND_ICON: begin
          tiles[index] = value[7:0];
        end
        KIND_ROW: begin
          if ({1'b0, row} < ROW_LIMIT) begin
            for (int x = 0; x < ROW_PIXELS; x++) begin
              b = tiles[tile_byte(x, row)];
              nib = x[0] ? b[7:4] : b[3:0];
              e.pixel = (nib == 4'd0) ? 16'd0 : bgr_to_rgba(palette[nib]);
              e.column = x[4:0];
              e.last = (e.column == LAST_COLUMN);
              expected_pixels = {expected_pixels, e};
            end
          end
        end
        default: ;
      endcase
    endfunction

    function void check_pixel(logic [15:0] pixel, logic [4:0] column, logic last);
      pix_item_t e;
      pixels_seen++;
      if (expected_pixels.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected pixel %h column %0d last %0b", pixel, column, last);
        return;
      end
      e = expected_pixels.pop_front();
      if (pixel !== e.pixel || column !== e.column || last !== e.last) begin
        mismatches++;
        if (mismatches <= 10)
          $display("pixel mismatch: expected %h col %0d last %0b, got %h col %0d last %0b",
                   e.pixel, e.column, e.last, pixel, column, last);
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  tipd_cmd_if cmd_ch ();
  tipd_pix_if pix_ch ();

  tiled_icon_palette_decoder u_dut (
    .clk (clk),
    .rst (rst),
    .cmd (cmd_ch),
    .pix (pix_ch)
  );

  icon_row_checker sb;
  int src_idle_pct;
  int sink_stall_pct;
  int idle_cycles;
  int rows_sent;
  int loads_sent;
  int ignored_sent;
  int done_rows [$];

  initial begin
    clk = 1'b0;
  end

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // pixel sink with random stalls
  always @(posedge clk) begin
    if (!rst && pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)
      sb.check_pixel(pix_ch.pixel, pix_ch.column, pix_ch.last);
    pix_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
  end

  always @(posedge clk) begin
    if (rst || (cmd_ch.valid === 1'b1 && cmd_ch.ready === 1'b1) ||
        (pix_ch.valid === 1'b1 && pix_ch.ready === 1'b1)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no item moved for %0d cycles", idle_cycles);
      $display("tb_tiled_icon_palette_decoder: errors");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_item(input logic [1:0] k, input logic [11:0] idx,
                           input logic [14:0] val, input logic [7:0] rw);
    while ($urandom_range(0, 99) < src_idle_pct) begin
      cmd_ch.valid <= 1'b0;
      @(posedge clk);
    end
    cmd_ch.valid <= 1'b1;
    cmd_ch.kind <= k;
    cmd_ch.index <= idx;
    cmd_ch.value <= val;
    cmd_ch.row <= rw;
    @(posedge clk);
    while (cmd_ch.ready !== 1'b1) @(posedge clk);
    sb.note_item(k, idx, val, rw);
    if (k == KIND_ROW) rows_sent++;
    else if (k == KIND_SPARE || (k == KIND_PAL && idx >= PAL_DEPTH)) ignored_sent++;
    else loads_sent++;
  endtask

  // fill all 16 bytes of one pixel row, then request it
  task automatic load_and_emit(input int y, input bit edge_values);
    logic [3:0]  b;
    logic [14:0] v;
    for (int i = 0; i < 16; i++) begin
      b = i[3:0];
      if (edge_values)
        v = (i == 6) ? 15'h7FFF : (i == 7) ? 15'h0100 : {7'd0, b, ~b};
      else if ($urandom_range(0, 3) == 0)
        v = 15'($urandom_range(0, 32767));
      else
        v = 15'($urandom_range(0, 255));
      send_item(KIND_ICON, 12'(sb.tile_byte(2 * i, y)), v, 8'($urandom_range(0, 255)));
    end
    send_item(KIND_ROW, 12'($urandom_range(0, 4095)), 15'($urandom_range(0, 32767)), 8'(y));
    done_rows = {done_rows, y};
  endtask

  initial begin
    int counted;
    int pick;
    int phase;
    logic [14:0] pv;
    rst = 1'b1;
    cmd_ch.valid = 1'b0;
    cmd_ch.kind = KIND_PAL;
    cmd_ch.index = '0;
    cmd_ch.value = '0;
    cmd_ch.row = '0;
    src_idle_pct = 0;
    sink_stall_pct = 0;
    sb = new();
    rows_sent = 0;
    loads_sent = 0;
    ignored_sent = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed: full palette with color extremes, ignored loads, edge row
    for (int e = 0; e < PAL_DEPTH; e++) begin
      pv = (e == 0 || e == 1) ? 15'h7FFF : (e == 2) ? 15'h001F : (e == 3) ? 15'h03E0 :
           (e == 4) ? 15'h7C00 : (e == 5) ? 15'h0000 : 15'($urandom_range(0, 32767));
      send_item(KIND_PAL, 12'(e), pv, 8'd0);
    end
    send_item(KIND_PAL, 12'd16, 15'h1234, 8'd0);
    send_item(KIND_PAL, 12'd17, 15'h2AAA, 8'd0);
    send_item(KIND_PAL, 12'hFFF, 15'h5555, 8'hFF);
    send_item(KIND_SPARE, 12'hFFF, 15'h7FFF, 8'hFF);
    load_and_emit(255, 1'b1);

    // random part in idling phases
    counted = 0;
    while (counted < RANDOM_ITEMS) begin
      phase = counted * 4 / RANDOM_ITEMS;
      case (phase)
        0: begin src_idle_pct = 0;  sink_stall_pct = 0;  end
        1: begin src_idle_pct = 80; sink_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  sink_stall_pct = 80; end
        default: begin src_idle_pct = 31; sink_stall_pct = 31; end
      endcase
      pick = $urandom_range(0, 99);
      if (done_rows.size() < 2 || pick < 55) begin
        load_and_emit((done_rows.size() == 1) ? 0 : $urandom_range(0, 255), 1'b0);
        counted += 17;
      end else if (pick < 70) begin
        send_item(KIND_ROW, 12'($urandom_range(0, 4095)), 15'($urandom_range(0, 32767)),
                  8'(done_rows[$urandom_range(0, done_rows.size() - 1)]));
        counted++;
      end else if (pick < 85) begin
        send_item(KIND_PAL, 12'($urandom_range(0, 15)), 15'($urandom_range(0, 32767)),
                  8'($urandom_range(0, 255)));
        counted++;
      end else if (pick < 92) begin
        send_item(KIND_PAL, 12'($urandom_range(16, 4095)), 15'($urandom_range(0, 32767)),
                  8'($urandom_range(0, 255)));
        counted++;
      end else begin
        send_item(KIND_SPARE, 12'($urandom_range(0, 4095)), 15'($urandom_range(0, 32767)),
                  8'($urandom_range(0, 255)));
        counted++;
      end
    end
    cmd_ch.valid <= 1'b0;

    while (sb.expected_pixels.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("run covered %0d row requests, %0d loads and %0d ignored items, %0d pixels",
             rows_sent, loads_sent, ignored_sent, sb.pixels_seen);
    $display("idling: none, sender 80 pct, receiver 80 pct, both 31 pct; %0d mismatches",
             sb.mismatches);
    if (sb.mismatches == 0 && sb.expected_pixels.size() == 0) begin
      $display("tb_tiled_icon_palette_decoder: clean");
    end else begin
      $display("tb_tiled_icon_palette_decoder: errors");
    end
    $finish;
  end

endmodule
